// File: hw/rtl/pdpp_pkg.sv
// Shared types, character classes, parser states and drive kinds for the drive prefix parser.
package pdpp_pkg;

  // Position counter width and its saturation limit.
  localparam int unsigned POS_W     = 16;
  localparam logic [POS_W-1:0] POS_LIMIT = 16'hFFFF;

  // Character classes produced by the front end.
  localparam logic [2:0] CLS_OTHER = 3'd0;
  localparam logic [2:0] CLS_SLASH = 3'd1;
  localparam logic [2:0] CLS_QMARK = 3'd2;
  localparam logic [2:0] CLS_DOT   = 3'd3;
  localparam logic [2:0] CLS_COLON = 3'd4;
  localparam logic [2:0] CLS_LET_U = 3'd5;
  localparam logic [2:0] CLS_LET_N = 3'd6;
  localparam logic [2:0] CLS_LET_C = 3'd7;

  // Drive kinds as reported on the output.
  localparam logic [2:0] K_NONE     = 3'd0;
  localparam logic [2:0] K_VOLUME   = 3'd1;
  localparam logic [2:0] K_UNC      = 3'd2;
  localparam logic [2:0] K_DEV_LIT  = 3'd3;
  localparam logic [2:0] K_DEV_NORM = 3'd4;
  localparam logic [2:0] K_DEV_UNC  = 3'd5;

  // Parser states.
  localparam logic [3:0] S_START     = 4'd0;
  localparam logic [3:0] S_SL        = 4'd1;
  localparam logic [3:0] S_SLSL      = 4'd2;
  localparam logic [3:0] S_Q         = 4'd3;
  localparam logic [3:0] S_QSL       = 4'd4;
  localparam logic [3:0] S_QU        = 4'd5;
  localparam logic [3:0] S_QUN       = 4'd6;
  localparam logic [3:0] S_QUNC      = 4'd7;
  localparam logic [3:0] S_DOT       = 4'd8;
  localparam logic [3:0] S_DOTSL     = 4'd9;
  localparam logic [3:0] S_OTHER     = 4'd10;
  localparam logic [3:0] S_SERVER    = 4'd11;
  localparam logic [3:0] S_SERVER_SL = 4'd12;
  localparam logic [3:0] S_SHARE     = 4'd13;
  localparam logic [3:0] S_LITERAL   = 4'd14;
  localparam logic [3:0] S_NORMAL    = 4'd15;

  // One classified character as it waits in the queue.
  typedef struct packed {
    logic [2:0] cls;
    logic       last;
    logic       empty;
  } q_item_t;

  // Queue head as seen by the back end.
  typedef struct packed {
    logic    valid;
    q_item_t item;
  } q_head_t;

endpackage

// File: hw/rtl/pdpp_front.sv
// Front end: classifies each incoming character and holds it in a two-entry queue.
module pdpp_front
  import pdpp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [20:0] code_point,
  input  logic        last_char,
  input  logic        empty_path,
  output q_head_t     head,
  input  logic        pop
);

  q_item_t    entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  q_item_t    cls_item;
  logic       push;

  always_comb begin
    cls_item.last  = last_char;
    cls_item.empty = empty_path;
    if (code_point inside {21'h00005C, 21'h00002F}) begin
      cls_item.cls = CLS_SLASH;
    end else if (code_point == 21'h00003F) begin
      cls_item.cls = CLS_QMARK;
    end else if (code_point == 21'h00002E) begin
      cls_item.cls = CLS_DOT;
    end else if (code_point == 21'h00003A) begin
      cls_item.cls = CLS_COLON;
    end else if (code_point inside {21'h000055, 21'h000075}) begin
      cls_item.cls = CLS_LET_U;
    end else if (code_point inside {21'h00004E, 21'h00006E}) begin
      cls_item.cls = CLS_LET_N;
    end else if (code_point inside {21'h000043, 21'h000063}) begin
      cls_item.cls = CLS_LET_C;
    end else begin
      cls_item.cls = CLS_OTHER;
    end
  end

  assign in_stall   = (count == 2'd2);
  assign push       = in_valid && !in_stall;
  assign head.valid = (count != 2'd0);
  assign head.item  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= cls_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: hw/rtl/pdpp_back.sv
// Back end: prefix state machine and the registered result stage.
module pdpp_back
  import pdpp_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  q_head_t          head,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [2:0]       drive_kind,
  output logic             drive_valid,
  output logic [POS_W-1:0] prefix_length,
  output logic             needs_separator
);

  logic [3:0]       state, state_next;
  logic [POS_W-1:0] pos, pos_next;
  logic [2:0]       kind, kind_next;
  logic             fvalid, fvalid_next;
  logic             decided, decided_next;

  logic             emit;
  logic [2:0]       e_kind;
  logic             e_valid;
  logic [POS_W-1:0] e_len;

  logic             done;
  logic [POS_W-1:0] len;
  logic [POS_W-1:0] pos_inc;
  logic             sl;
  logic [2:0]       cls;

  assign pop     = head.valid && (!out_valid || !out_stall);
  assign cls     = head.item.cls;
  assign sl      = (cls == CLS_SLASH);
  assign pos_inc = (pos == POS_LIMIT) ? pos : pos + 1'b1;

  always_comb begin
    state_next   = state;
    pos_next     = pos;
    kind_next    = kind;
    fvalid_next  = fvalid;
    decided_next = decided;
    emit         = 1'b0;
    e_kind       = K_NONE;
    e_valid      = 1'b1;
    e_len        = '0;
    done         = 1'b0;
    len          = pos;

    if (pop) begin
      if (head.item.empty) begin
        // An empty path abandons whatever was in progress.
        state_next   = S_START;
        pos_next     = '0;
        kind_next    = K_NONE;
        fvalid_next  = 1'b1;
        decided_next = 1'b0;
        emit         = 1'b1;
      end else if (decided) begin
        if (head.item.last) begin
          state_next   = S_START;
          pos_next     = '0;
          kind_next    = K_NONE;
          fvalid_next  = 1'b1;
          decided_next = 1'b0;
        end
      end else begin
        case (state)
          S_START: state_next = sl ? S_SL : S_OTHER;
          S_SL: begin
            if (sl) begin
              kind_next   = K_UNC;
              fvalid_next = 1'b0;
              state_next  = S_SLSL;
            end else begin
              done = 1'b1;
            end
          end
          S_SLSL: begin
            if (sl) begin
              state_next = S_SHARE;
            end else if (cls == CLS_QMARK) begin
              state_next = S_Q;
            end else if (cls == CLS_DOT) begin
              state_next = S_DOT;
            end else begin
              state_next = S_SERVER;
            end
          end
          S_Q: begin
            if (sl) begin
              kind_next   = K_DEV_LIT;
              fvalid_next = 1'b0;
              state_next  = S_QSL;
            end else begin
              state_next = S_SERVER;
            end
          end
          S_QSL: begin
            if (sl) begin
              done = 1'b1;
            end else begin
              fvalid_next = 1'b1;
              state_next  = (cls == CLS_LET_U) ? S_QU : S_SHARE;
            end
          end
          S_QU: begin
            if (sl) begin
              done = 1'b1;
            end else begin
              state_next = (cls == CLS_LET_N) ? S_QUN : S_LITERAL;
            end
          end
          S_QUN: begin
            if (sl) begin
              done = 1'b1;
            end else begin
              state_next = (cls == CLS_LET_C) ? S_QUNC : S_LITERAL;
            end
          end
          S_QUNC: begin
            if (sl) begin
              kind_next  = K_DEV_UNC;
              state_next = S_SERVER;
            end else begin
              state_next = S_LITERAL;
            end
          end
          S_DOT: begin
            if (sl) begin
              kind_next   = K_DEV_NORM;
              fvalid_next = 1'b0;
              state_next  = S_DOTSL;
            end else begin
              state_next = S_SERVER;
            end
          end
          S_DOTSL: begin
            if (sl) begin
              done = 1'b1;
            end else begin
              fvalid_next = 1'b1;
              state_next  = S_NORMAL;
            end
          end
          S_OTHER: begin
            if (cls == CLS_COLON) begin
              kind_next = K_VOLUME;
              len       = pos_inc;
            end else begin
              kind_next = K_NONE;
            end
            done = 1'b1;
          end
          S_SERVER: begin
            if (sl) begin
              state_next = S_SERVER_SL;
            end
          end
          S_SERVER_SL: begin
            if (sl) begin
              done = 1'b1;
            end else begin
              fvalid_next = 1'b1;
              state_next  = S_SHARE;
            end
          end
          default: begin
            // Share, device literal and device normalized end at a separator.
            if (sl) begin
              done = 1'b1;
            end
          end
        endcase

        if (!done) begin
          pos_next = pos_inc;
          if (head.item.last) begin
            done = 1'b1;
            len  = pos_inc;
          end
        end

        if (done) begin
          emit    = 1'b1;
          e_kind  = kind_next;
          e_valid = fvalid_next;
          e_len   = (kind_next == K_NONE) ? '0 : len;
          if (head.item.last) begin
            state_next   = S_START;
            pos_next     = '0;
            kind_next    = K_NONE;
            fvalid_next  = 1'b1;
            decided_next = 1'b0;
          end else begin
            decided_next = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_START;
      pos     <= '0;
      kind    <= K_NONE;
      fvalid  <= 1'b1;
      decided <= 1'b0;
    end else begin
      state   <= state_next;
      pos     <= pos_next;
      kind    <= kind_next;
      fvalid  <= fvalid_next;
      decided <= decided_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      drive_kind      <= e_kind;
      drive_valid     <= e_valid;
      prefix_length   <= e_len;
      needs_separator <= (e_len != '0) && e_valid && (e_kind != K_VOLUME)
                         && (e_kind != K_DEV_NORM);
    end
  end

endmodule

// File: hw/rtl/path_drive_prefix_parser.sv
// Top level of the drive prefix parser: front end, queue and back end joined together.
//
//   channel  direction  handshake            payload
//   in       receive    in_valid / in_stall  code_point, last_char, empty_path
//   out      send       out_valid/out_stall  drive_kind, drive_valid, prefix_length,
//                                            needs_separator
//
// One character is taken per cycle while in_stall is low. The character that decides a
// result is written into the queue register, stepped by the back end and then held in
// the registered result stage until it is taken.
// The throughput of one item per cycle, while the output is not stalled, is set by the
// state step in the back end, which pops one queued character each cycle.
// Reset is synchronous and active high; it empties the queue, drops the pending result
// and returns the parser to its start state.
// A stall on the output holds the result register and stops the back end; the front
// queue then absorbs up to two further characters before in_stall rises.
module path_drive_prefix_parser
  import pdpp_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [20:0]      code_point,
  input  logic             last_char,
  input  logic             empty_path,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [2:0]       drive_kind,
  output logic             drive_valid,
  output logic [POS_W-1:0] prefix_length,
  output logic             needs_separator
);

  // Queue head travels from the front end to the back end as one bundle; the back end
  // answers with a pop whenever the head is valid and its result register can take a new value.
  q_head_t head;
  logic    pop;

  pdpp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .code_point (code_point),
    .last_char  (last_char),
    .empty_path (empty_path),
    .head       (head),
    .pop        (pop)
  );

  pdpp_back u_back (
    .clk             (clk),
    .rst             (rst),
    .head            (head),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .drive_kind      (drive_kind),
    .drive_valid     (drive_valid),
    .prefix_length   (prefix_length),
    .needs_separator (needs_separator)
  );

  // A result with no drive never reports a length.
  a_none_no_len: assert property (@(posedge clk) disable iff (rst)
    (out_valid && drive_kind == K_NONE) |-> (prefix_length == '0))
    else $error("kind none reported with a nonzero prefix length");

  // The separator flag only follows a valid, nonempty prefix of a suitable kind.
  a_sep_rule: assert property (@(posedge clk) disable iff (rst)
    (out_valid && needs_separator) |->
      (drive_valid && prefix_length != '0 && drive_kind != K_VOLUME
       && drive_kind != K_DEV_NORM))
    else $error("separator flag set on an unsuitable prefix");

  // A result can only appear once the parser has seen something to decide on.
  a_out_after_in: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(head.valid))
    else $error("result appeared with no queued character behind it");

endmodule
